>>> hdl/tmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmh_pkg: shared types and codes of the timer min-heap
// Entry, request and result layouts, command and result-kind codes.
// ----------------------------------------------------------------------------
package tmh_pkg;

	localparam int DL_W = 32;
	localparam int HD_W = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic KIND_EXPIRED = 1'b0;
	localparam logic KIND_DROPPED = 1'b1;

	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [HD_W-1:0] handle;
	} tmh_entry_t;

	typedef struct packed {
		logic            cmd;
		logic [DL_W-1:0] deadline;
		logic [HD_W-1:0] handle;
		logic [DL_W-1:0] now;
	} tmh_req_t;

	typedef struct packed {
		logic            kind;
		logic [HD_W-1:0] out_handle;
		logic [DL_W-1:0] out_deadline;
		logic            last;
	} tmh_rsp_t;

endpackage

>>> hdl/timer_min_heap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_min_heap_unit: binary min-heap timer queue
// Pending timers ordered by deadline; insert sifts up, tick pops every
// expired timer smallest first. Built as a chain of per-level heap cells.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload    | direction
//  ---------+------------------------+------------+----------
//  request  | start high, busy low   | req        | in
//  result   | rsp_strobe, one cycle  | rsp        | out
//
//  Insert with room: take the request and place the entry at the tail level,
//  then at each non-root level visited read the parent level, compare and
//  write, and settle at the root if reached; a full heap answers with a drop.
//  Tick: take the request, check the root, and for each expired timer sift
//  the last entry down, reading the child level, comparing and writing at
//  each level (a level with no child left just writes); it ends with a
//  failing root check or an empty-heap check.
//  The rate is set by the sift token that visits one level cell at a time
//  and by the registered read port of each level memory.
//  Reset clears the entry count and all control; level memories keep
//  whatever they hold and are only read below the entry count.
//  Results cannot be stalled: rsp_strobe marks each for exactly one cycle.
//
module timer_min_heap_unit
	import tmh_pkg::*;
#(
	parameter int HEAP_DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  tmh_req_t req,
	output logic     rsp_strobe,
	output tmh_rsp_t rsp
);

	localparam int NLEV = $clog2(HEAP_DEPTH + 1);
	localparam int LW   = NLEV - 1;
	localparam int CW   = $clog2(HEAP_DEPTH + 1);
	localparam int LVW  = $clog2(NLEV);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP    = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_SIFT  = 3'd4;

	// level of a heap slot from its one-based position
	function automatic logic [LVW-1:0] msb_of(input logic [CW-1:0] v);
		logic [LVW-1:0] r;
		r = '0;
		for (int b = 0; b < CW; b++) begin
			if (v[b]) begin
				r = LVW'(b);
			end
		end
		return r;
	endfunction

	logic [2:0]     state_q;
	logic [2:0]     state_d;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_d;
	logic [DL_W-1:0] now_q;
	tmh_entry_t     pend_q;
	logic           pend_vld_q;
	logic           pend_vld_d;
	logic           pend_ld;
	logic [LVW-1:0] lst_lvl_q;
	tmh_rsp_t       rsp_q;
	logic           rsp_strobe_q;
	logic           emit;
	tmh_rsp_t       emit_rsp;

	logic           full;
	logic           hit;
	tmh_entry_t     root;
	tmh_entry_t     last_ent;
	logic [CW-1:0]  ins_g1;
	logic [LVW-1:0] ins_lvl;
	logic [LW-1:0]  ins_idx;
	logic [LVW-1:0] fet_lvl;
	logic [LW-1:0]  fet_idx;
	logic           fet_vld;
	logic           inj_vld;
	logic [LVW-1:0] inj_lvl;
	logic [LW-1:0]  inj_idx;
	tmh_entry_t     inj_ent;
	logic           sift_dn;

	// per-level cell outputs
	tmh_entry_t     c_rd0 [NLEV];
	tmh_entry_t     c_rd1 [NLEV];
	tmh_entry_t     c_tent [NLEV];
	logic [LW-1:0]  c_tdn_idx [NLEV];
	logic [LW-1:0]  c_tup_idx [NLEV];
	logic [LW-1:0]  c_rqk0 [NLEV];
	logic [LW-1:0]  c_rqk1 [NLEV];
	logic [LW-1:0]  c_rqp [NLEV];
	logic [NLEV-1:0] c_tdn_vld;
	logic [NLEV-1:0] c_tup_vld;
	logic [NLEV-1:0] c_fin;

	assign busy       = (state_q != S_IDLE);
	assign rsp        = rsp_q;
	assign rsp_strobe = rsp_strobe_q;
	assign sift_dn    = (state_q == S_SIFT);

	assign full     = (cnt_q == CW'(HEAP_DEPTH));
	assign root     = c_rd0[0];
	assign last_ent = c_rd1[lst_lvl_q];
	assign hit      = (root.deadline <= now_q);

	// tail slot for an insert, and the slot of the last entry for a pop
	assign ins_g1  = cnt_q + CW'(1);
	assign ins_lvl = msb_of(ins_g1);
	assign ins_idx = LW'(ins_g1 ^ (CW'(1) << ins_lvl));
	assign fet_lvl = msb_of(cnt_q);
	assign fet_idx = LW'(cnt_q ^ (CW'(1) << fet_lvl));

	// token injection and last-entry fetch
	always_comb begin
		inj_vld          = 1'b0;
		inj_lvl          = ins_lvl;
		inj_idx          = ins_idx;
		inj_ent.deadline = req.deadline;
		inj_ent.handle   = req.handle;
		fet_vld          = 1'b0;
		if (state_q == S_IDLE && start && req.cmd == CMD_INSERT && !full) begin
			inj_vld = 1'b1;
		end
		if (state_q == S_EVAL && hit && cnt_q != CW'(1)) begin
			// move the last entry to the root and sift it down
			inj_vld = 1'b1;
			inj_lvl = '0;
			inj_idx = '0;
			inj_ent = last_ent;
		end
		if (state_q == S_FETCH && cnt_q != '0) begin
			fet_vld = 1'b1;
		end
	end

	// sequencer: hold one expired timer back so the final one can carry last
	always_comb begin
		state_d               = state_q;
		cnt_d                 = cnt_q;
		pend_vld_d            = pend_vld_q;
		pend_ld               = 1'b0;
		emit                  = 1'b0;
		emit_rsp.kind         = KIND_EXPIRED;
		emit_rsp.out_handle   = pend_q.handle;
		emit_rsp.out_deadline = pend_q.deadline;
		emit_rsp.last         = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.cmd == CMD_TICK) begin
						pend_vld_d = 1'b0;
						state_d    = S_FETCH;
					end else if (full) begin
						// drop the insert and report it
						emit                  = 1'b1;
						emit_rsp.kind         = KIND_DROPPED;
						emit_rsp.out_handle   = req.handle;
						emit_rsp.out_deadline = req.deadline;
					end else begin
						cnt_d   = cnt_q + CW'(1);
						state_d = S_UP;
					end
				end
			end
			S_UP: begin
				if (|c_fin) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				if (cnt_q == '0) begin
					emit    = pend_vld_q;
					state_d = S_IDLE;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (hit) begin
					emit          = pend_vld_q;
					emit_rsp.last = 1'b0;
					pend_ld       = 1'b1;
					pend_vld_d    = 1'b1;
					cnt_d         = cnt_q - CW'(1);
					state_d       = (cnt_q == CW'(1)) ? S_FETCH : S_SIFT;
				end else begin
					emit    = pend_vld_q;
					state_d = S_IDLE;
				end
			end
			S_SIFT: begin
				if (|c_fin) begin
					state_d = S_FETCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			pend_vld_q   <= 1'b0;
			rsp_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			pend_vld_q   <= pend_vld_d;
			rsp_strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			now_q <= req.now;
		end
		if (pend_ld) begin
			pend_q <= root;
		end
		if (fet_vld) begin
			lst_lvl_q <= fet_lvl;
		end
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	// chain of level cells, root at level 0
	for (genvar L = 0; L < NLEV; L++) begin : g_lvl
		logic          tin_vld;
		logic [LW-1:0] tin_idx;
		tmh_entry_t    tin_ent;
		logic [LW-1:0] ra0;
		logic [LW-1:0] ra1;
		tmh_entry_t    kid0;
		tmh_entry_t    kid1;
		tmh_entry_t    par;
		logic          dn_vld;
		logic [LW-1:0] dn_idx;
		tmh_entry_t    dn_ent;
		logic [LW-1:0] dk0;
		logic [LW-1:0] dk1;
		logic          up_vld;
		logic [LW-1:0] up_idx;
		tmh_entry_t    up_ent;
		logic [LW-1:0] up_ra;

		if (L > 0) begin : g_above
			assign dn_vld = c_tdn_vld[L-1];
			assign dn_idx = c_tdn_idx[L-1];
			assign dn_ent = c_tent[L-1];
			assign dk0    = c_rqk0[L-1];
			assign dk1    = c_rqk1[L-1];
			assign par    = c_rd0[L-1];
		end else begin : g_top
			assign dn_vld = 1'b0;
			assign dn_idx = '0;
			assign dn_ent = '0;
			assign dk0    = '0;
			assign dk1    = '0;
			assign par    = '0;
		end

		if (L < NLEV - 1) begin : g_below
			assign up_vld = c_tup_vld[L+1];
			assign up_idx = c_tup_idx[L+1];
			assign up_ent = c_tent[L+1];
			assign up_ra  = c_rqp[L+1];
			assign kid0   = c_rd0[L+1];
			assign kid1   = c_rd1[L+1];
		end else begin : g_leaf
			assign up_vld = 1'b0;
			assign up_idx = '0;
			assign up_ent = '0;
			assign up_ra  = '0;
			assign kid0   = '0;
			assign kid1   = '0;
		end

		// only one token is in flight, so the sources never collide
		always_comb begin
			tin_vld = 1'b0;
			tin_idx = inj_idx;
			tin_ent = inj_ent;
			if (inj_vld && inj_lvl == LVW'(L)) begin
				tin_vld = 1'b1;
			end else if (dn_vld) begin
				tin_vld = 1'b1;
				tin_idx = dn_idx;
				tin_ent = dn_ent;
			end else if (up_vld) begin
				tin_vld = 1'b1;
				tin_idx = up_idx;
				tin_ent = up_ent;
			end
		end

		assign ra0 = dk0 | up_ra;
		assign ra1 = dk1 | ((fet_vld && fet_lvl == LVW'(L)) ? fet_idx : '0);

		tmh_level_cell #(
			.LEVEL (L),
			.NLEV  (NLEV),
			.LW    (LW),
			.CW    (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.sift_dn  (sift_dn),
			.cnt      (cnt_q),
			.tin_vld  (tin_vld),
			.tin_idx  (tin_idx),
			.tin_ent  (tin_ent),
			.ra0      (ra0),
			.ra1      (ra1),
			.rd0      (c_rd0[L]),
			.rd1      (c_rd1[L]),
			.kid0     (kid0),
			.kid1     (kid1),
			.par      (par),
			.tout_ent (c_tent[L]),
			.tdn_vld  (c_tdn_vld[L]),
			.tdn_idx  (c_tdn_idx[L]),
			.tup_vld  (c_tup_vld[L]),
			.tup_idx  (c_tup_idx[L]),
			.rq_kid0  (c_rqk0[L]),
			.rq_kid1  (c_rqk1[L]),
			.rq_par   (c_rqp[L]),
			.fin      (c_fin[L])
		);
	end

endmodule

>>> hdl/tmh_level_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmh_level_cell: one level of the binary heap
// Holds the entries of one heap level and, while the sift token sits here,
// compares against the neighbor level and hands the token on.
// ----------------------------------------------------------------------------
module tmh_level_cell
	import tmh_pkg::*;
#(
	parameter int LEVEL = 0,
	parameter int NLEV  = 6,
	parameter int LW    = 5,
	parameter int CW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sift_dn,
	input  logic [CW-1:0] cnt,
	input  logic          tin_vld,
	input  logic [LW-1:0] tin_idx,
	input  tmh_entry_t    tin_ent,
	input  logic [LW-1:0] ra0,
	input  logic [LW-1:0] ra1,
	output tmh_entry_t    rd0,
	output tmh_entry_t    rd1,
	input  tmh_entry_t    kid0,
	input  tmh_entry_t    kid1,
	input  tmh_entry_t    par,
	output tmh_entry_t    tout_ent,
	output logic          tdn_vld,
	output logic [LW-1:0] tdn_idx,
	output logic          tup_vld,
	output logic [LW-1:0] tup_idx,
	output logic [LW-1:0] rq_kid0,
	output logic [LW-1:0] rq_kid1,
	output logic [LW-1:0] rq_par,
	output logic          fin
);

	localparam int AW       = (LEVEL > 0) ? LEVEL : 1;
	localparam int SZ       = 1 << AW;
	localparam int GW       = CW + 1;
	localparam int KID_BASE = (1 << (LEVEL + 1)) - 1;
	localparam bit HAS_KIDS = (LEVEL < NLEV - 1);
	localparam bit HAS_PAR  = (LEVEL > 0);

	tmh_entry_t    mem [SZ];
	tmh_entry_t    ent_q;
	logic [LW-1:0] idx_q;
	logic          vld_q;
	logic          ph_q;
	logic          nxt_vld;
	logic          nxt_ph;
	logic [LW-1:0] kid_idx;
	logic [GW-1:0] kid_g;
	logic          left_ok;
	logic          right_ok;
	logic          pick_r;
	tmh_entry_t    pick;
	logic          we;
	tmh_entry_t    wd;

	assign kid_idx  = idx_q << 1;
	assign kid_g    = GW'(KID_BASE) + (GW'(idx_q) << 1);
	assign left_ok  = HAS_KIDS && (kid_g < GW'(cnt));
	assign right_ok = HAS_KIDS && ((kid_g + GW'(1)) < GW'(cnt));
	// on a tie the left child wins
	assign pick_r   = right_ok && (kid1.deadline < kid0.deadline);
	assign pick     = pick_r ? kid1 : kid0;

	assign tout_ent = ent_q;
	assign tdn_idx  = kid_idx | LW'(pick_r);
	assign tup_idx  = idx_q >> 1;

	always_comb begin
		we      = 1'b0;
		wd      = ent_q;
		fin     = 1'b0;
		tdn_vld = 1'b0;
		tup_vld = 1'b0;
		rq_kid0 = '0;
		rq_kid1 = '0;
		rq_par  = '0;
		nxt_vld = vld_q;
		nxt_ph  = ph_q;
		if (vld_q) begin
			if (!ph_q) begin
				// fetch the neighbor level, or settle here when there is none
				if (sift_dn) begin
					if (left_ok) begin
						rq_kid0 = kid_idx;
						rq_kid1 = kid_idx | LW'(1);
						nxt_ph  = 1'b1;
					end else begin
						we      = 1'b1;
						fin     = 1'b1;
						nxt_vld = 1'b0;
					end
				end else begin
					if (HAS_PAR) begin
						rq_par = idx_q >> 1;
						nxt_ph = 1'b1;
					end else begin
						we      = 1'b1;
						fin     = 1'b1;
						nxt_vld = 1'b0;
					end
				end
			end else begin
				nxt_vld = 1'b0;
				nxt_ph  = 1'b0;
				we      = 1'b1;
				if (sift_dn) begin
					if (pick.deadline < ent_q.deadline) begin
						wd      = pick;
						tdn_vld = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end else begin
					if (ent_q.deadline < par.deadline) begin
						wd      = par;
						tup_vld = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
			end
		end
		if (tin_vld) begin
			nxt_vld = 1'b1;
			nxt_ph  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			ph_q  <= 1'b0;
		end else begin
			vld_q <= nxt_vld;
			ph_q  <= nxt_ph;
		end
	end

	always_ff @(posedge clk) begin
		if (tin_vld) begin
			idx_q <= tin_idx;
			ent_q <= tin_ent;
		end
		if (we) begin
			mem[idx_q[AW-1:0]] <= wd;
		end
		rd0 <= mem[ra0[AW-1:0]];
		rd1 <= mem[ra1[AW-1:0]];
	end

endmodule

>>> hdl/tmh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmh_checker: port-level checks of the timer min-heap
// Relates results to the requests that caused them.
// ----------------------------------------------------------------------------
module tmh_checker
	import tmh_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input tmh_req_t req,
	input logic     rsp_strobe,
	input tmh_rsp_t rsp
);

	// a drop answers an insert taken on the edge before
	a_drop_after_insert: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.kind == KIND_DROPPED
		|-> $past(start && !busy && req.cmd == CMD_INSERT))
		else $error("dropped result without a preceding insert request");

	// a drop echoes the rejected timer
	a_drop_echo: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.kind == KIND_DROPPED
		|-> rsp.last && rsp.out_handle == $past(req.handle)
			&& rsp.out_deadline == $past(req.deadline))
		else $error("dropped result does not match the insert request");

	// expiries come only out of a running tick
	a_expire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.kind == KIND_EXPIRED |-> $past(busy))
		else $error("expired result while idle");

	// a non-final expiry shows while the tick is still running
	a_expire_more: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.kind == KIND_EXPIRED && !rsp.last |-> busy)
		else $error("tick ended without a final result");

endmodule

bind timer_min_heap_unit tmh_checker u_chk (.*);
